>>> design/dpt_pkg.sv
`timescale 1ns / 1ps
package dpt_pkg;
  localparam int NumW = 63;
  localparam int TableLen = 12;
  typedef logic [NumW-1:0] num_t;

  // witness base table
  function automatic logic [5:0] base_at(input logic [3:0] k);
    logic [5:0] r;
    case (k)
      4'd0: r = 6'd2;
      4'd1: r = 6'd3;
      4'd2: r = 6'd5;
      4'd3: r = 6'd7;
      4'd4: r = 6'd11;
      4'd5: r = 6'd13;
      4'd6: r = 6'd17;
      4'd7: r = 6'd19;
      4'd8: r = 6'd23;
      4'd9: r = 6'd29;
      4'd10: r = 6'd31;
      4'd11: r = 6'd37;
      default: r = 6'd2;
    endcase
    return r;
  endfunction
endpackage

>>> design/dpt_mulmod.sv
`timescale 1ns / 1ps
// Shared modular multiplier: one bit of b per cycle, double-and-add.
module dpt_mulmod (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dpt_pkg::num_t       a,
  input  dpt_pkg::num_t       b,
  input  dpt_pkg::num_t       m,
  output logic                done,
  output dpt_pkg::num_t       res
);
  logic busy;
  logic [5:0] bit_idx;
  dpt_pkg::num_t acc, ra, rb, rm;
  logic [63:0] dbl, dred, add;
  dpt_pkg::num_t step;

  // double, reduce, conditionally add, reduce
  always_comb begin
    dbl = {acc, 1'b0};
    dred = (dbl >= {1'b0, rm}) ? dbl - {1'b0, rm} : dbl;
    add = dred + {1'b0, ra};
    if (rb[bit_idx]) begin
      step = (add >= {1'b0, rm}) ? add[62:0] - rm : add[62:0];
    end else begin
      step = dred[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bit_idx <= 6'd62;
        acc <= '0;
        ra <= a;
        rb <= b;
        rm <= m;
      end else if (busy) begin
        acc <= step;
        bit_idx <= bit_idx - 6'd1;
        if (bit_idx == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign res = acc;
endmodule

>>> design/deterministic_primality_test_top.sv
`timescale 1ns / 1ps
// Each item runs through up to BASE_COUNT bases (at most TableLen), each tested by a
// series of modular multiplies in the shared multiplier.
// Even numbers and numbers below 4 skip the test and go from idle straight to the done state.
// One item at a time; ready is low while busy, so a new item is taken only once the last has left the done state.
// The result register lets the next item be accepted while the result waits.
// Synchronous active-high reset clears the sequencer, the result valid flag and the multiply start.
module deterministic_primality_test_top #(
  parameter int BASE_COUNT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        number_valid,
  output logic        number_ready,
  input  logic [62:0] number,
  output logic        is_prime_valid,
  input  logic        is_prime_ready,
  output logic        is_prime
);
  localparam int NB = (BASE_COUNT > dpt_pkg::TableLen) ? dpt_pkg::TableLen : BASE_COUNT;
  localparam logic [2:0] S_IDLE = 3'd0, S_SPLIT = 3'd1, S_BASE = 3'd2, S_POW = 3'd3,
                         S_SQR = 3'd4, S_CHK = 3'd5, S_DONE = 3'd6;
  logic [2:0] state;
  dpt_pkg::num_t n, d, e, acc, b, x;
  logic [5:0] s, i;
  logic [3:0] k;
  logic phase;   // 0: issue next multiply, 1: wait for it
  logic verdict;
  logic mm_start, mm_done;
  logic mm_issue;
  dpt_pkg::num_t mm_a, mm_b, mm_res;
  dpt_pkg::num_t nm1;
  logic [5:0] base;

  assign nm1 = n - 63'd1;
  assign base = dpt_pkg::base_at(k);
  assign number_ready = (state == S_IDLE);

  // start a multiply in the power loop, the first squaring, or a chained squaring
  assign mm_issue = ((state == S_POW) && !phase && (e != '0)) ||
                    ((state == S_CHK) && (x != 63'd1) && (x != nm1) && (i < s)) ||
                    ((state == S_SQR) && mm_done && (mm_res != nm1) && ((i + 6'd1) < s));

  dpt_mulmod u_mm (.clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(n),
                   .done(mm_done), .res(mm_res));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      is_prime_valid <= 1'b0;
      mm_start <= 1'b0;
    end else begin
      mm_start <= mm_issue;
      if (is_prime_valid && is_prime_ready && (state != S_DONE)) is_prime_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (number_valid && number_ready) begin
            n <= number;
            if (!number[0]) begin
              verdict <= (number == 63'd2);
              state <= S_DONE;
            end else if (number <= 63'd3) begin
              verdict <= (number == 63'd3);
              state <= S_DONE;
            end else begin
              d <= number - 63'd1;
              s <= '0;
              state <= S_SPLIT;
            end
          end
        end
        // strip factors of two, one per cycle
        S_SPLIT: begin
          if (d[0]) begin
            k <= '0;
            verdict <= 1'b1;
            state <= S_BASE;
          end else begin
            d <= d >> 1;
            s <= s + 6'd1;
          end
        end
        S_BASE: begin
          if (k == 4'(NB)) begin
            state <= S_DONE;
          end else if ({57'd0, base} > n - 63'd2) begin
            k <= k + 4'd1;
          end else begin
            acc <= 63'd1;
            b <= {57'd0, base};
            e <= d;
            phase <= 1'b0;
            state <= S_POW;
          end
        end
        // square-and-multiply: multiply acc by b on a set bit, then square b and shift
        S_POW: begin
          if (!phase) begin
            if (e == '0) begin
              x <= acc;
              i <= 6'd1;
              state <= S_CHK;
            end else if (e[0]) begin
              mm_a <= acc; mm_b <= b; phase <= 1'b1;
            end else begin
              mm_a <= b; mm_b <= b; phase <= 1'b1;
            end
          end else if (mm_done) begin
            phase <= 1'b0;
            if (e[0]) begin
              acc <= mm_res;
              e[0] <= 1'b0;
            end else begin
              b <= mm_res;
              e <= e >> 1;
            end
          end
        end
        S_CHK: begin
          if (x == 63'd1 || x == nm1) begin
            k <= k + 4'd1;
            state <= S_BASE;
          end else if (i >= s) begin
            verdict <= 1'b0;
            state <= S_DONE;
          end else begin
            mm_a <= x; mm_b <= x;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_done) begin
            if (mm_res == nm1) begin
              k <= k + 4'd1;
              state <= S_BASE;
            end else begin
              x <= mm_res;
              i <= i + 6'd1;
              if (i + 6'd1 >= s) begin
                verdict <= 1'b0;
                state <= S_DONE;
              end else begin
                mm_a <= mm_res; mm_b <= mm_res;
              end
            end
          end
        end
        S_DONE: begin
          if (!is_prime_valid || is_prime_ready) begin
            is_prime <= verdict;
            is_prime_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/dpt_checker.sv
`timescale 1ns / 1ps
module dpt_checker (
  input logic clk,
  input logic rst,
  input logic number_valid,
  input logic number_ready,
  input logic is_prime_valid,
  input logic is_prime_ready,
  input logic is_prime
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    is_prime_valid && !is_prime_ready |=> is_prime_valid && $stable(is_prime))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    number_valid && number_ready |=> !number_ready)
    else $error("second item accepted while busy");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    number_valid && !number_ready |=> number_valid)
    else $error("input valid dropped");
endmodule

bind deterministic_primality_test_top dpt_checker u_chk (
  .clk(clk), .rst(rst), .number_valid(number_valid), .number_ready(number_ready),
  .is_prime_valid(is_prime_valid), .is_prime_ready(is_prime_ready), .is_prime(is_prime));

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  localparam int BaseCount = 12;
  localparam logic [5:0] WitnessBases [12] = '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
                                              6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37};

  logic clk;
  logic rst;
  logic number_valid;
  logic number_ready;
  dpt_pkg::num_t number;
  logic is_prime_valid;
  logic is_prime_ready;
  logic is_prime;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches = 0;
  bit expected_prime [$];
  dpt_pkg::num_t expected_num [$];

  deterministic_primality_test_top dut (
    .clk(clk),
    .rst(rst),
    .number_valid(number_valid),
    .number_ready(number_ready),
    .number(number),
    .is_prime_valid(is_prime_valid),
    .is_prime_ready(is_prime_ready),
    .is_prime(is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact modular product, full-width intermediate
  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % m;
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, sq, m);
      e = e >> 1;
      sq = mod_mul(sq, sq, m);
    end
    return acc;
  endfunction

  // Miller-Rabin with the fixed witness set
  function automatic bit predict_prime(dpt_pkg::num_t num);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] x;
    int s;
    bit hit;
    n = {1'b0, num};
    if (!n[0]) return n == 64'd2;
    if (n <= 64'd3) return n == 64'd3;
    d = n - 64'd1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int k = 0; k < BaseCount && k < 12; k++) begin
      if (64'(WitnessBases[k]) > n - 64'd2) continue;
      x = mod_pow(64'(WitnessBases[k]), d, n);
      if (x == 64'd1 || x == n - 64'd1) continue;
      hit = 1'b0;
      for (int i = 1; i < s; i++) begin
        x = mod_mul(x, x, n);
        if (x == n - 64'd1) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  // drive one item; called at a rising edge, returns at the accepting edge
  task automatic send_number(dpt_pkg::num_t v);
    bit rdy;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      number_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    number_valid <= 1'b1;
    number <= v;
    forever begin
      @(negedge clk);
      rdy = number_ready;
      @(posedge clk);
      if (rdy) break;
    end
    expected_prime.push_back(predict_prime(v));
    expected_num.push_back(v);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) is_prime_ready <= 1'b0;
    else is_prime_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // sample away from the edge, check at the edge
  bit took_result;
  bit seen_prime;
  always @(negedge clk) begin
    took_result = is_prime_valid && is_prime_ready && !rst;
    seen_prime = is_prime;
  end

  always @(posedge clk) begin
    if (took_result) begin
      if (expected_prime.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result is_prime=%0b", seen_prime);
      end else begin
        if (seen_prime !== expected_prime[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("number %0d: expected is_prime=%0b got %0b",
                     expected_num[0], expected_prime[0], seen_prime);
        end
        void'(expected_prime.pop_front());
        void'(expected_num.pop_front());
      end
    end
  end

  // small cases, special composites, extremes of the field
  task automatic test_directed();
    dpt_pkg::num_t vals [$];
    vals = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd25, 63'd37, 63'd41,
             63'd49, 63'd561, 63'd65537, 63'd3215031751, 63'd2147483647,
             63'h4000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF,
             63'd9223372036854775783, 63'd4611685975477714963,
             63'd3825123056546413051, 63'h5555_5555_5555_5555};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  // mostly narrow odd candidates so runs stay short; a few full-width ones
  task automatic test_random(int count);
    dpt_pkg::num_t v;
    int w;
    for (int i = 0; i < count; i++) begin
      v = 63'({$urandom, $urandom});
      w = ($urandom_range(99) < 8) ? 63 : $urandom_range(2, 24);
      if (w < 63) v = v & ((63'd1 << w) - 63'd1);
      if ($urandom_range(99) < 80) v[0] = 1'b1;
      send_number(v);
    end
  endtask

  task automatic wait_drained();
    number_valid <= 1'b0;
    while (expected_prime.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    number_valid = 1'b0;
    number = '0;
    send_idle_pct = 15;
    recv_stall_pct = 84;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(27);
    send_idle_pct = 84;
    recv_stall_pct = 15;
    test_random(27);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(27);
    wait_drained();
    repeat (200) @(posedge clk);

    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // run limit
  initial begin
    #400_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> files.f
design/dpt_pkg.sv
design/dpt_mulmod.sv
design/deterministic_primality_test_top.sv
design/dpt_checker.sv
verif/testbench.sv
